// File: rtl/core/crcmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcmm_pkg: shared types, codes and functions of the multi-model crc-16 engine
// Model tables, byte update, reflection helpers and the front-to-back op format.
// ----------------------------------------------------------------------------
package crcmm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_MODEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 2'd1;

    // queue depths
    localparam int OP_QUEUE_DEPTH  = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // model codes
    localparam logic [3:0] MDL_IBM         = 4'd0;
    localparam logic [3:0] MDL_MAXIM       = 4'd1;
    localparam logic [3:0] MDL_USB         = 4'd2;
    localparam logic [3:0] MDL_MODBUS      = 4'd3;
    localparam logic [3:0] MDL_CCITT       = 4'd4;
    localparam logic [3:0] MDL_CCITT_FALSE = 4'd5;
    localparam logic [3:0] MDL_X25         = 4'd6;
    localparam logic [3:0] MDL_XMODEM      = 4'd7;
    localparam logic [3:0] MDL_DNP         = 4'd8;

    // polynomials and masks
    localparam logic [15:0] POLY_8005 = 16'h8005;
    localparam logic [15:0] POLY_1021 = 16'h1021;
    localparam logic [15:0] POLY_3D65 = 16'h3D65;
    localparam logic [15:0] ALL_ONES  = 16'hFFFF;
    localparam logic [15:0] MSB_MASK  = 16'h8000;

    // one transfer from front to back
    typedef struct packed {
        logic        feed_en;    // run feed_byte through the crc
        logic [7:0]  feed_byte;
        logic        last;       // close the message, emit a result
        logic        verify;
        logic        too_short;
        logic [15:0] stored;     // trailing crc in verify mode
    } t_op;

    // one result
    typedef struct packed {
        logic [15:0] crc_value;
        logic        crc_match;
        logic        too_short;
    } t_res;

    function automatic logic [15:0] model_init(input logic [3:0] m);
        logic [15:0] v;
        unique case (m)
            MDL_USB, MDL_MODBUS, MDL_CCITT_FALSE, MDL_X25: v = ALL_ONES;
            default:                                      v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] model_poly(input logic [3:0] m);
        logic [15:0] v;
        unique case (m)
            MDL_IBM, MDL_MAXIM, MDL_USB, MDL_MODBUS:         v = POLY_8005;
            MDL_CCITT, MDL_CCITT_FALSE, MDL_X25, MDL_XMODEM: v = POLY_1021;
            MDL_DNP:                                         v = POLY_3D65;
            default:                                         v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] model_xor(input logic [3:0] m);
        logic [15:0] v;
        unique case (m)
            MDL_MAXIM, MDL_USB, MDL_X25, MDL_DNP: v = ALL_ONES;
            default:                              v = '0;
        endcase
        return v;
    endfunction

    function automatic logic model_refl(input logic [3:0] m);
        logic v;
        unique case (m)
            MDL_IBM, MDL_MAXIM, MDL_USB, MDL_MODBUS, MDL_CCITT, MDL_X25, MDL_DNP: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7-i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [15:0] rev16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) begin
            r[15-i] = v[i];
        end
        return r;
    endfunction

    // eight msb-first shift steps through the polynomial
    function automatic logic [15:0] crc_feed8(input logic [15:0] c_in,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & MSB_MASK) != '0) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/core/crcmm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcmm_fifo: small first-in first-out queue
// Register array with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module crcmm_fifo #(
    parameter int DEPTH = crcmm_pkg::OP_QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    // status and read data
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/core/crcmm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcmm_front: byte intake and classification
// Holds back the two trailing bytes in verify mode, counts message length and
// turns each accepted byte into an op for the crc back end.
// ----------------------------------------------------------------------------
module crcmm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic              i_check_mode,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_full,
    input  logic              i_op_full,
    output logic              o_op_push,
    output crcmm_pkg::t_op    o_op
);
    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_count, n_count;
    logic       accept;
    logic       two_seen;

    assign o_full    = i_op_full;
    assign accept    = i_push && !i_op_full;
    assign o_op_push = accept;
    assign two_seen  = r_count[1];

    // op classification
    always_comb begin
        o_op.verify    = i_check_mode;
        o_op.last      = i_last_byte;
        o_op.too_short = i_check_mode && !two_seen;
        o_op.stored    = {i_data_byte, r_held1};
        if (i_check_mode) begin
            o_op.feed_en   = two_seen;
            o_op.feed_byte = r_held0;
        end else begin
            o_op.feed_en   = 1'b1;
            o_op.feed_byte = i_data_byte;
        end
    end

    // hold-back and length state
    always_comb begin
        n_held0 = r_held0;
        n_held1 = r_held1;
        n_count = r_count;
        priority if (i_restart || (accept && i_last_byte)) begin
            n_held0 = '0;
            n_held1 = '0;
            n_count = '0;
        end else if (accept) begin
            if (i_check_mode) begin
                n_held0 = r_held1;
                n_held1 = i_data_byte;
            end
            n_count = (r_count == 2'd3) ? r_count : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0 <= '0;
            r_held1 <= '0;
            r_count <= '0;
        end else begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/core/crcmm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcmm_back: crc update and result formation
// Runs the op's byte, when enabled, through the selected polynomial and, on the
// closing op, reflects for reflected models, applies the final xor and in verify mode compares against the stored crc.
// ----------------------------------------------------------------------------
module crcmm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  logic [15:0]       i_restart_init,
    input  logic [3:0]        i_crc_model,
    input  logic              i_op_empty,
    input  crcmm_pkg::t_op    i_op,
    output logic              o_op_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output crcmm_pkg::t_res   o_res
);
    logic [15:0] r_crc, n_crc;
    logic [15:0] feed_crc;
    logic [15:0] calc;
    logic [7:0]  in_byte;
    logic        refl;

    // take an op unless it closes a message and the result queue is full
    assign o_op_pop   = !i_op_empty && (!i_op.last || !i_res_full);
    assign o_res_push = o_op_pop && i_op.last;

    // byte update
    assign refl     = crcmm_pkg::model_refl(i_crc_model);
    assign in_byte  = refl ? crcmm_pkg::rev8(i_op.feed_byte) : i_op.feed_byte;
    assign feed_crc = i_op.feed_en
                    ? crcmm_pkg::crc_feed8(r_crc, in_byte, crcmm_pkg::model_poly(i_crc_model))
                    : r_crc;

    // finishing
    assign calc = (refl ? crcmm_pkg::rev16(feed_crc) : feed_crc)
                ^ crcmm_pkg::model_xor(i_crc_model);

    always_comb begin
        priority if (i_op.verify && i_op.too_short) begin
            o_res.crc_value = '0;
            o_res.crc_match = 1'b0;
            o_res.too_short = 1'b1;
        end else if (i_op.verify) begin
            o_res.crc_value = calc;
            o_res.crc_match = (i_op.stored == calc);
            o_res.too_short = 1'b0;
        end else begin
            o_res.crc_value = calc;
            o_res.crc_match = 1'b0;
            o_res.too_short = 1'b0;
        end
    end

    // running crc
    always_comb begin
        n_crc = r_crc;
        priority if (i_restart) begin
            n_crc = i_restart_init;
        end else if (o_op_pop && i_op.last) begin
            n_crc = crcmm_pkg::model_init(i_crc_model);
        end else if (o_op_pop) begin
            n_crc = feed_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= crcmm_pkg::model_init(crcmm_pkg::MDL_IBM);
        end else begin
            r_crc <= n_crc;
        end
    end

endmodule

// File: rtl/core/crc16_multi_model_engine_top.sv
`timescale 1ns / 1ps
// accepted bytes are stored in the op queue; results of closing ops are stored in the result queue
// throughput: one byte per cycle while the op queue is not full, limited by the eight-bit crc
// update in the back end; op and result queues let intake and pop side stall independently
// reset: synchronous active-low; model ibm, compute mode, crc and hold-back state cleared,
// both queues empty
// ----------------------------------------------------------------------------
// crc16_multi_model_engine_top: multi-model crc-16 compute and verify engine
// Front end classifies bytes, back end updates the crc, queues in between.
// ----------------------------------------------------------------------------
module crc16_multi_model_engine_top #(
    parameter int OP_QUEUE_DEPTH  = crcmm_pkg::OP_QUEUE_DEPTH,
    parameter int RES_QUEUE_DEPTH = crcmm_pkg::RES_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [crcmm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [crcmm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // byte input
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    // results
    output logic                           empty,
    input  logic                           pop,
    output logic [15:0]                    o_crc_value,
    output logic                           o_crc_match,
    output logic                           o_too_short
);
    localparam int OP_W  = $bits(crcmm_pkg::t_op);
    localparam int RES_W = $bits(crcmm_pkg::t_res);

    logic [3:0]      r_crc_model;
    logic            r_check_mode;
    logic            cfg_model_wr, cfg_mode_wr, cfg_restart;
    logic [3:0]      next_model;
    logic [15:0]     restart_init;

    crcmm_pkg::t_op  front_op, back_op;
    crcmm_pkg::t_res back_res, out_res;
    logic            op_push, op_full, op_pop, op_empty;
    logic            res_push, res_full;

    // configuration decode
    assign cfg_model_wr = i_cfg_we && (i_cfg_idx == crcmm_pkg::REG_CRC_MODEL);
    assign cfg_mode_wr  = i_cfg_we && (i_cfg_idx == crcmm_pkg::REG_CHECK_MODE);
    assign cfg_restart  = cfg_model_wr || cfg_mode_wr;
    assign next_model   = cfg_model_wr ? i_cfg_data[3:0] : r_crc_model;
    assign restart_init = crcmm_pkg::model_init(next_model);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_model  <= crcmm_pkg::MDL_IBM;
            r_check_mode <= 1'b0;
        end else begin
            if (cfg_model_wr) begin
                r_crc_model <= i_cfg_data[3:0];
            end
            if (cfg_mode_wr) begin
                r_check_mode <= i_cfg_data[0];
            end
        end
    end

    // byte intake
    crcmm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (cfg_restart),
        .i_check_mode (r_check_mode),
        .i_push       (push),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_full       (full),
        .i_op_full    (op_full),
        .o_op_push    (op_push),
        .o_op         (front_op)
    );

    // op queue
    crcmm_fifo #(
        .DEPTH (OP_QUEUE_DEPTH),
        .WIDTH (OP_W)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (front_op),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_data  (back_op),
        .o_empty (op_empty)
    );

    // crc back end
    crcmm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (cfg_restart),
        .i_restart_init (restart_init),
        .i_crc_model    (r_crc_model),
        .i_op_empty     (op_empty),
        .i_op           (back_op),
        .o_op_pop       (op_pop),
        .i_res_full     (res_full),
        .o_res_push     (res_push),
        .o_res          (back_res)
    );

    // result queue
    crcmm_fifo #(
        .DEPTH (RES_QUEUE_DEPTH),
        .WIDTH (RES_W)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_crc_value = out_res.crc_value;
    assign o_crc_match = out_res.crc_match;
    assign o_too_short = out_res.too_short;

    // assertions
    a_short_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_too_short) |-> (o_crc_value == '0 && !o_crc_match))
        else $error("short message result carries crc or match");

    a_compute_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !r_check_mode) |-> (!o_crc_match && !o_too_short))
        else $error("compute mode result has verify flags set");

    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into full result queue");

    a_op_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_push |-> !op_full)
        else $error("op pushed into full op queue");

endmodule
